FILE: design/tcg_pkg.sv
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared types and fixed constants: operation codes, result kinds, font store
// geometry and the cursor command that the top level sends to the cursor unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tcg_pkg;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] OP_DRAW   = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_CURSOR = 2'd2;

	// Result kinds carried in the output tuser.
	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Character code that performs a newline instead of drawing.
	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	// Font store geometry.
	localparam int FONT_DEPTH = 2048;
	localparam int FONT_AW    = 11;

	// Widths of coordinates and colours.
	localparam int COORD_W = 12;
	localparam int COLOR_W = 16;

	// Most pixel writes that a single draw produces.
	localparam int MAX_PIXELS = 64;
	localparam int PIX_CNT_W  = 6;

	// Control state of the top level sequencer.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_PIXEL,
		ST_STATUS
	} state_t;

	// Command to the cursor unit for one accepted item.
	typedef struct packed {
		logic               set;
		logic               newline;
		logic               advance;
		logic [COORD_W-1:0] set_x;
		logic [COORD_W-1:0] set_y;
	} cursor_cmd_t;

endpackage

`default_nettype wire

FILE: design/tcg_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tcg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: design/tcg_cursor.sv
// ----------------------------------------------------------------------------
// Text console cursor unit
// Holds the cursor and applies set, newline and advance commands, reporting
// whether the command calls for a scroll of one text line.
// ----------------------------------------------------------------------------
`default_nettype none

module tcg_cursor #(
	parameter int GLYPH_WIDTH  = 8,
	parameter int GLYPH_HEIGHT = 8,
	parameter int SCREEN_COLS  = 640,
	parameter int SCREEN_ROWS  = 480
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_valid,
	input  wire tcg_pkg::cursor_cmd_t         cmd,
	output logic [tcg_pkg::COORD_W-1:0]       col,
	output logic [tcg_pkg::COORD_W-1:0]       row,
	output logic                              scroll
);

	localparam int CW = tcg_pkg::COORD_W;

	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [CW:0]   down_sum;
	logic [CW:0]   right_sum;
	logic          at_bottom;
	logic          at_right;
	logic [CW-1:0] nl_row;
	logic [CW-1:0] col_d;
	logic [CW-1:0] row_d;

	// Candidate positions one text line down and one glyph to the right.
	always_comb begin
		down_sum  = {1'b0, row_q} + (CW+1)'(GLYPH_HEIGHT);
		right_sum = {1'b0, col_q} + (CW+1)'(GLYPH_WIDTH);
		at_bottom = down_sum >= (CW+1)'(SCREEN_ROWS);
		at_right  = right_sum >= (CW+1)'(SCREEN_COLS);
		nl_row    = at_bottom ? row_q : down_sum[CW-1:0];
	end

	// Next cursor and scroll request for the command.
	always_comb begin
		col_d  = col_q;
		row_d  = row_q;
		scroll = 1'b0;
		if (cmd.set) begin
			col_d = cmd.set_x;
			row_d = cmd.set_y;
		end else if (cmd.newline || (cmd.advance && at_right)) begin
			col_d  = '0;
			row_d  = nl_row;
			scroll = at_bottom;
		end else if (cmd.advance) begin
			col_d = right_sum[CW-1:0];
		end
	end

	// Cursor registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd_valid) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	assign col = col_q;
	assign row = row_q;

endmodule

`default_nettype wire

FILE: design/tcg_glyph_ser.sv
// ----------------------------------------------------------------------------
// Glyph row serialiser
// Takes one glyph row into a shift register and hands out one pixel bit per
// shift, rightmost pixel first, with the column that the bit lands on.
// ----------------------------------------------------------------------------
`default_nettype none

module tcg_glyph_ser #(
	parameter int GLYPH_WIDTH = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          load,
	input  wire logic [7:0]                    row_bits,
	input  wire logic [tcg_pkg::COORD_W-1:0]   origin_x,
	input  wire logic                          shift,
	output logic                               bit_out,
	output logic [tcg_pkg::COORD_W-1:0]        pix_x,
	output logic                               col_last
);

	localparam int CW   = tcg_pkg::COORD_W;
	localparam int COLW = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;

	logic [7:0]      bits_q;
	logic [CW-1:0]   x_q;
	logic [COLW-1:0] col_cnt_q;

	// Shift register and column counters; the column runs right to left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
		end else if (load) begin
			col_cnt_q <= '0;
		end else if (shift) begin
			col_cnt_q <= col_cnt_q + COLW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bits_q <= row_bits;
			x_q    <= origin_x + CW'(GLYPH_WIDTH - 1);
		end else if (shift) begin
			bits_q <= {1'b0, bits_q[7:1]};
			x_q    <= x_q - CW'(1);
		end
	end

	assign bit_out  = bits_q[0];
	assign pix_x    = x_q;
	assign col_last = col_cnt_q == COLW'(GLYPH_WIDTH - 1);

endmodule

`default_nettype wire

FILE: design/text_console_glyph_renderer.sv
// A draw item turns into one pixel write per cycle while the output register
// can take a new word, shifted out of a glyph row register one bit at a time;
// each glyph row is first fetched from the font memory (read, then load into
// the shift register). A draw gives min(GLYPH_WIDTH * GLYPH_HEIGHT, 64) pixel
// writes, a set cursor or newline one status word and a glyph row load none.
// One item is worked on at a time; the next is taken once the last result of
// the current one sits in the output register. The font memory is not cleared
// at reset: draw only glyphs whose rows have been loaded.
// ----------------------------------------------------------------------------
// Text console glyph renderer
// Loads a bitmap font, keeps a text cursor and expands characters into
// pixel writes for a framebuffer, with newline, advance and scroll requests.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_glyph_renderer #(
	parameter int GLYPH_WIDTH  = 8,
	parameter int GLYPH_HEIGHT = 8,
	parameter int SCREEN_COLS  = 640,
	parameter int SCREEN_ROWS  = 480
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input words.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// code[7:0], row[11:8], glyph_bits[19:12], fg[35:20], bg[51:36],
	// advance[52], set_x[64:53], set_y[76:65], zero[79:77]
	input  wire logic [79:0] s_tdata,
	// op[1:0]
	input  wire logic [1:0]  s_tuser,
	// Result words.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// pixel_x[11:0], pixel_y[23:12], color[39:24], scroll_up[40],
	// cursor_x[52:41], cursor_y[64:53], zero[71:65]
	output logic [71:0]      m_tdata,
	// kind[0]
	output logic             m_tuser,
	// last
	output logic             m_tlast
);

	localparam int CW    = tcg_pkg::COORD_W;
	localparam int CLW   = tcg_pkg::COLOR_W;
	localparam int AW    = tcg_pkg::FONT_AW;
	localparam int PCW   = tcg_pkg::PIX_CNT_W;
	localparam int RW    = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
	localparam int TOTAL = (GLYPH_WIDTH * GLYPH_HEIGHT > tcg_pkg::MAX_PIXELS) ?
		tcg_pkg::MAX_PIXELS : GLYPH_WIDTH * GLYPH_HEIGHT;

	// Input fields.
	logic [1:0]     in_op;
	logic [7:0]     in_code;
	logic [3:0]     in_row;
	logic [7:0]     in_glyph_bits;
	logic [CLW-1:0] in_fg;
	logic [CLW-1:0] in_bg;
	logic           in_advance;
	logic [CW-1:0]  in_set_x;
	logic [CW-1:0]  in_set_y;

	assign in_op         = s_tuser;
	assign in_code       = s_tdata[7:0];
	assign in_row        = s_tdata[11:8];
	assign in_glyph_bits = s_tdata[19:12];
	assign in_fg         = s_tdata[35:20];
	assign in_bg         = s_tdata[51:36];
	assign in_advance    = s_tdata[52];
	assign in_set_x      = s_tdata[64:53];
	assign in_set_y      = s_tdata[76:65];

	tcg_pkg::state_t      state_q;
	tcg_pkg::state_t      state_d;
	tcg_pkg::cursor_cmd_t cur_cmd;

	logic           acc;
	logic           is_newline;
	logic           can_load;
	logic           last_pix;
	logic           rd_en;
	logic           ser_load;
	logic           pix_emit;
	logic           stat_emit;
	logic           load_wr;

	logic [CW-1:0]  cur_col;
	logic [CW-1:0]  cur_row;
	logic           cur_scroll;

	logic [AW-1:0]  base_q;
	logic [RW-1:0]  row_i_q;
	logic [CLW-1:0] fg_q;
	logic [CLW-1:0] bg_q;
	logic           scroll_q;
	logic [CW-1:0]  org_x_q;
	logic [CW-1:0]  py_q;
	logic [PCW-1:0] pix_cnt_q;

	logic [AW-1:0]  wr_addr;
	logic [AW-1:0]  rd_addr;
	logic [7:0]     rd_data;
	logic           ser_bit;
	logic [CW-1:0]  ser_x;
	logic           col_last;

	logic           m_tvalid_q;
	logic           kind_q;
	logic           last_q;
	logic           out_scroll_q;
	logic [CW-1:0]  out_px_q;
	logic [CW-1:0]  out_py_q;
	logic [CLW-1:0] out_color_q;
	logic [CW-1:0]  out_cx_q;
	logic [CW-1:0]  out_cy_q;

	// Handshake conditions.
	assign s_tready   = state_q == tcg_pkg::ST_IDLE;
	assign acc        = s_tvalid && s_tready;
	assign is_newline = in_code == tcg_pkg::NEWLINE_CODE;
	assign can_load   = !m_tvalid_q || m_tready;
	assign last_pix   = pix_cnt_q == PCW'(TOTAL - 1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcg_pkg::ST_IDLE: begin
				if (acc) begin
					if (in_op == tcg_pkg::OP_CURSOR) begin
						state_d = tcg_pkg::ST_STATUS;
					end else if (in_op == tcg_pkg::OP_DRAW) begin
						state_d = is_newline ? tcg_pkg::ST_STATUS : tcg_pkg::ST_READ;
					end
				end
			end
			tcg_pkg::ST_READ: state_d = tcg_pkg::ST_LOAD;
			tcg_pkg::ST_LOAD: state_d = tcg_pkg::ST_PIXEL;
			tcg_pkg::ST_PIXEL: begin
				if (can_load) begin
					if (last_pix) begin
						state_d = tcg_pkg::ST_IDLE;
					end else if (col_last) begin
						state_d = tcg_pkg::ST_READ;
					end
				end
			end
			tcg_pkg::ST_STATUS: begin
				if (can_load) begin
					state_d = tcg_pkg::ST_IDLE;
				end
			end
			default: state_d = tcg_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		rd_en     = 1'b0;
		ser_load  = 1'b0;
		pix_emit  = 1'b0;
		stat_emit = 1'b0;
		case (state_q)
			tcg_pkg::ST_READ:   rd_en     = 1'b1;
			tcg_pkg::ST_LOAD:   ser_load  = 1'b1;
			tcg_pkg::ST_PIXEL:  pix_emit  = can_load;
			tcg_pkg::ST_STATUS: stat_emit = can_load;
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Cursor command for the accepted word.
	always_comb begin
		cur_cmd.set     = in_op == tcg_pkg::OP_CURSOR;
		cur_cmd.newline = (in_op == tcg_pkg::OP_DRAW) && is_newline;
		cur_cmd.advance = (in_op == tcg_pkg::OP_DRAW) && !is_newline && in_advance;
		cur_cmd.set_x   = in_set_x;
		cur_cmd.set_y   = in_set_y;
	end

	tcg_cursor #(
		.GLYPH_WIDTH (GLYPH_WIDTH),
		.GLYPH_HEIGHT(GLYPH_HEIGHT),
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_cursor (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(acc),
		.cmd      (cur_cmd),
		.col      (cur_col),
		.row      (cur_row),
		.scroll   (cur_scroll)
	);

	// Font memory: glyph rows are written on a load, read row by row on a draw.
	assign load_wr = acc && (in_op == tcg_pkg::OP_LOAD) &&
		({1'b0, in_row} < 5'(GLYPH_HEIGHT));
	assign wr_addr = AW'(32'(in_code) * GLYPH_HEIGHT + 32'(in_row));
	assign rd_addr = base_q + AW'(row_i_q);

	tcg_ram #(
		.WIDTH(8),
		.DEPTH(tcg_pkg::FONT_DEPTH)
	) u_font (
		.clk    (clk),
		.wr_en  (load_wr),
		.wr_addr(wr_addr),
		.wr_data(in_glyph_bits),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	tcg_glyph_ser #(
		.GLYPH_WIDTH(GLYPH_WIDTH)
	) u_ser (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (ser_load),
		.row_bits(rd_data),
		.origin_x(org_x_q),
		.shift   (pix_emit),
		.bit_out (ser_bit),
		.pix_x   (ser_x),
		.col_last(col_last)
	);

	// Item context captured at acceptance: glyph base, colours, origin, scroll.
	always_ff @(posedge clk) begin
		if (acc) begin
			base_q   <= AW'(32'(in_code) * GLYPH_HEIGHT);
			fg_q     <= in_fg;
			bg_q     <= in_bg;
			scroll_q <= cur_scroll;
			org_x_q  <= cur_col;
		end
	end

	// Glyph row and pixel counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_i_q   <= '0;
			py_q      <= '0;
			pix_cnt_q <= '0;
		end else if (acc) begin
			row_i_q   <= '0;
			py_q      <= cur_row;
			pix_cnt_q <= '0;
		end else if (pix_emit) begin
			if (last_pix) begin
				pix_cnt_q <= '0;
			end else begin
				pix_cnt_q <= pix_cnt_q + PCW'(1);
				if (col_last) begin
					row_i_q <= row_i_q + RW'(1);
					py_q    <= py_q + CW'(1);
				end
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pix_emit || stat_emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pix_emit) begin
			kind_q       <= tcg_pkg::KIND_PIXEL;
			out_px_q     <= ser_x;
			out_py_q     <= py_q;
			out_color_q  <= ser_bit ? fg_q : bg_q;
			out_scroll_q <= last_pix && scroll_q;
			last_q       <= last_pix;
			out_cx_q     <= cur_col;
			out_cy_q     <= cur_row;
		end else if (stat_emit) begin
			kind_q       <= tcg_pkg::KIND_STATUS;
			out_px_q     <= '0;
			out_py_q     <= '0;
			out_color_q  <= '0;
			out_scroll_q <= scroll_q;
			last_q       <= 1'b1;
			out_cx_q     <= cur_col;
			out_cy_q     <= cur_row;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {7'd0, out_cy_q, out_cx_q, out_scroll_q, out_color_q,
		out_py_q, out_px_q};

	// A scroll request only ever rides on the last word of an item.
	a_scroll_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[40] |-> m_tlast)
		else $error("scroll request on a word that is not the last");

	// A status word always closes its item.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == tcg_pkg::KIND_STATUS) |-> m_tlast)
		else $error("status word without last");

	// The pixel counter is back at zero whenever a new item may be taken.
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcg_pkg::ST_IDLE) |-> (pix_cnt_q == '0))
		else $error("pixel counter not cleared between items");

endmodule

`default_nettype wire

FILE: verif/text_console_glyph_renderer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console glyph renderer checker
// Watches both stream channels of the renderer, keeps its own copy of the font
// and the cursor, works out the pixel and status words that each accepted
// input word must cause, and compares every result word with the oldest one.
// ----------------------------------------------------------------------------

module tcg_render_checker
	import tcg_pkg::*;
#(
	parameter int GLYPH_WIDTH  = 8,
	parameter int GLYPH_HEIGHT = 8,
	parameter int SCREEN_COLS  = 640,
	parameter int SCREEN_ROWS  = 480
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [79:0] s_tdata,
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [71:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        m_tlast,
	output int               errors,
	output int               pending
);

	// One expected result word.
	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [COLOR_W-1:0] color;
		logic               scroll_up;
		logic [COORD_W-1:0] cursor_x;
		logic [COORD_W-1:0] cursor_y;
		logic               last;
	} pixel_word_t;

	// Beyond this many, mismatches are still counted but no longer printed.
	localparam int PRINT_CAP = 200;

	logic [7:0]         glyph_mem [FONT_DEPTH];
	logic [COORD_W-1:0] cur_col;
	logic [COORD_W-1:0] cur_row;
	pixel_word_t        expected_words [$];
	pixel_word_t        oldest;
	int                 fail_count;

	// Moves the cursor to the start of the next text line; a move past the
	// bottom keeps the row and asks for a scroll instead.
	function automatic bit line_feed();
		logic [31:0] y;
		y = cur_row + GLYPH_HEIGHT;
		cur_col = '0;
		line_feed = 1'b0;
		if (y >= SCREEN_ROWS) begin
			line_feed = 1'b1;
			y = y - GLYPH_HEIGHT;
		end
		cur_row = y[COORD_W-1:0];
	endfunction

	// Updates the font and cursor for one input word and queues its results.
	task automatic render_item(input logic [1:0] op, input logic [79:0] d);
		pixel_word_t w;
		pixel_word_t batch [$];
		logic [7:0]  code;
		logic [3:0]  row;
		logic [7:0]  g;
		logic [31:0] t;
		int          idx;
		bit          scroll;
		code = d[7:0];
		row = d[11:8];
		scroll = 1'b0;
		case (op)
			OP_LOAD: begin
				if (row < GLYPH_HEIGHT) begin
					idx = (code * GLYPH_HEIGHT + row) % FONT_DEPTH;
					glyph_mem[idx] = d[19:12];
				end
			end
			OP_CURSOR: begin
				cur_col = d[64:53];
				cur_row = d[76:65];
				w = '0;
				w.kind = KIND_STATUS;
				batch.push_back(w);
			end
			OP_DRAW: begin
				if (code == NEWLINE_CODE) begin
					scroll = line_feed();
					w = '0;
					w.kind = KIND_STATUS;
					batch.push_back(w);
				end else begin
					// Rows top down; bit 0 of a row is its rightmost pixel.
					for (int i = 0; i < GLYPH_HEIGHT; i++) begin
						idx = (code * GLYPH_HEIGHT + i) % FONT_DEPTH;
						g = glyph_mem[idx];
						for (int j = 0; j < GLYPH_WIDTH; j++) begin
							if (batch.size() < MAX_PIXELS) begin
								w = '0;
								w.kind = KIND_PIXEL;
								t = cur_col + GLYPH_WIDTH - 1 - j;
								w.pixel_x = t[COORD_W-1:0];
								t = cur_row + i;
								w.pixel_y = t[COORD_W-1:0];
								w.color = g[j % 8] ? d[35:20] : d[51:36];
								batch.push_back(w);
							end
						end
					end
					// Advance one cell, wrapping at the right edge.
					if (d[52]) begin
						t = cur_col + GLYPH_WIDTH;
						if (t >= SCREEN_COLS)
							scroll = line_feed();
						else
							cur_col = t[COORD_W-1:0];
					end
				end
			end
			default: ;
		endcase
		// Every word of an item reports the cursor after the whole item.
		for (int k = 0; k < batch.size(); k++) begin
			batch[k].cursor_x = cur_col;
			batch[k].cursor_y = cur_row;
			if (k == batch.size() - 1) begin
				batch[k].scroll_up = scroll;
				batch[k].last = 1'b1;
			end
			expected_words.push_back(batch[k]);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			if (fail_count < PRINT_CAP)
				$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Inputs are taken before outputs: a result never leaves in the cycle
	// that its input word is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			cur_col = '0;
			cur_row = '0;
			fail_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				render_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					if (fail_count < PRINT_CAP)
						$error("result word with no expectation waiting");
					fail_count++;
				end else begin
					oldest = expected_words.pop_front();
					check_field("kind", oldest.kind, m_tuser);
					check_field("pixel_x", oldest.pixel_x, m_tdata[11:0]);
					check_field("pixel_y", oldest.pixel_y, m_tdata[23:12]);
					check_field("color", oldest.color, m_tdata[39:24]);
					check_field("scroll_up", oldest.scroll_up, m_tdata[40]);
					check_field("cursor_x", oldest.cursor_x, m_tdata[52:41]);
					check_field("cursor_y", oldest.cursor_y, m_tdata[64:53]);
					check_field("last", oldest.last, m_tlast);
				end
			end
			errors <= fail_count;
			pending <= expected_words.size();
		end
	end

endmodule

FILE: verif/text_console_glyph_renderer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console glyph renderer testbench
// Loads glyphs, moves the cursor and draws characters, first through edge
// cases and then at random, with random idling on both channels; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------

module text_console_glyph_renderer_tb;
	import tcg_pkg::*;

	localparam int GLYPH_WIDTH  = 8;
	localparam int GLYPH_HEIGHT = 8;
	localparam int SCREEN_COLS  = 640;
	localparam int SCREEN_ROWS  = 480;

	// Operation code that the block ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic [1:0]  s_tuser = OP_DRAW;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	int          errors;
	int          pending;

	// Sender idling on or off, and the request for a long receiver hold-off.
	bit          idle_on = 1'b1;
	bit          hold_req = 1'b0;

	// Rows loaded so far per glyph, and the glyphs safe to draw.
	logic [7:0]  rows_loaded [256];
	logic [7:0]  drawable [$];
	logic [7:0]  edge_rows [8] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F};

	text_console_glyph_renderer #(
		.GLYPH_WIDTH (GLYPH_WIDTH),
		.GLYPH_HEIGHT(GLYPH_HEIGHT),
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	tcg_render_checker #(
		.GLYPH_WIDTH (GLYPH_WIDTH),
		.GLYPH_HEIGHT(GLYPH_HEIGHT),
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) render_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Offers one input word, after a random gap when idling is on, and
	// returns at the edge where it is accepted.
	task automatic send(input logic [1:0] op, input logic [7:0] code, input logic [3:0] row,
		input logic [7:0] bits, input logic [15:0] fg, input logic [15:0] bg,
		input logic adv, input logic [11:0] sx, input logic [11:0] sy);
		int gap;
		int r;
		gap = 0;
		if (idle_on) begin
			r = $urandom_range(0, 9);
			if (r >= 9)
				gap = $urandom_range(8, 30);
			else if (r >= 6)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {3'b000, sy, sx, adv, bg, fg, bits, row, code};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Unused fields of each word carry random values.
	task automatic load_row(input logic [7:0] code, input logic [3:0] row,
		input logic [7:0] bits);
		send(OP_LOAD, code, row, bits, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (row < GLYPH_HEIGHT) begin
			rows_loaded[code][row] = 1'b1;
			if (rows_loaded[code] == 8'hFF && !(code inside {drawable}))
				drawable.push_back(code);
		end
	endtask

	task automatic draw(input logic [7:0] code, input logic [15:0] fg, input logic [15:0] bg,
		input logic adv);
		send(OP_DRAW, code, $urandom, $urandom, fg, bg, adv, $urandom, $urandom);
	endtask

	task automatic place_cursor(input logic [11:0] x, input logic [11:0] y);
		send(OP_CURSOR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, x, y);
	endtask

	// Stops offering and waits until every expected result word has come.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Receiver pacing: random stalls, mostly short, now and then long, with
	// stretches of steady readiness, and one long hold-off on request.
	initial begin : sink_pacing
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (stall_left == 0 && run_left == 0) begin
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
						: $urandom_range(0, 3);
					run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 4);
				end
				if (stall_left > 0) begin
					m_tready <= 1'b0;
					stall_left--;
				end else begin
					m_tready <= 1'b1;
					run_left--;
				end
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int          pick;
		bit          saved_idle;
		logic [7:0]  c;
		foreach (rows_loaded[i])
			rows_loaded[i] = 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: glyph with edge row patterns, ignored loads and the
		// unused operation.
		for (int r = 0; r < 8; r++)
			load_row(8'hFF, r[3:0], edge_rows[r]);
		load_row(8'h00, 4'd8, 8'hFF);
		load_row(8'h00, 4'd15, 8'h00);
		send(OP_UNUSED, 8'hFF, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 12'hFFF, 12'hFFF);

		// Directed: colour extremes, advance and no advance.
		place_cursor(12'd0, 12'd0);
		draw(8'hFF, 16'hFFFF, 16'h0000, 1'b1);
		draw(8'hFF, 16'h0000, 16'hFFFF, 1'b0);

		// Directed: wrap at the right edge on the bottom line, then newline
		// at the bottom, both asking for a scroll.
		place_cursor(12'd632, 12'd472);
		draw(8'hFF, 16'h1234, 16'hABCD, 1'b1);
		draw(NEWLINE_CODE, 16'h0000, 16'h0000, 1'b0);

		// Directed: plain newline from the top.
		place_cursor(12'd0, 12'd0);
		draw(NEWLINE_CODE, 16'hFFFF, 16'hFFFF, 1'b1);

		// Directed: cursor far off screen, so that coordinates wrap.
		place_cursor(12'hFFF, 12'hFFF);
		draw(8'hFF, 16'h5A5A, 16'hA5A5, 1'b1);
		place_cursor(12'hFFF, 12'hFFF);
		draw(NEWLINE_CODE, 16'h0000, 16'hFFFF, 1'b0);

		// Directed: pixels past the right edge of the screen.
		place_cursor(12'd636, 12'd0);
		draw(8'hFF, 16'hF00F, 16'h0FF0, 1'b0);

		// Random: mostly draws of loaded glyphs, with loads, cursor moves,
		// newlines and some noise.
		for (int k = 0; k < 75; k++) begin
			if (k % 25 == 0)
				idle_on = ($urandom_range(0, 3) != 0);

			// Receiver holds off while the sender keeps offering draws,
			// then the sender waits for everything to come out.
			if (k == 60) begin
				saved_idle = idle_on;
				idle_on = 1'b0;
				hold_req = 1'b1;
				repeat (6)
					draw(drawable[$urandom_range(0, drawable.size() - 1)],
						$urandom, $urandom, 1'b1);
				drain();
				idle_on = saved_idle;
			end

			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				draw(drawable[$urandom_range(0, drawable.size() - 1)],
					$urandom, $urandom, $urandom_range(0, 4) != 0);
			end else if (pick < 63) begin
				draw(NEWLINE_CODE, $urandom, $urandom, $urandom);
			end else if (pick < 71) begin
				c = $urandom;
				for (int r = 0; r < 8; r++)
					load_row(c, r[3:0], $urandom);
			end else if (pick < 83) begin
				if ($urandom_range(0, 9) < 7)
					place_cursor(12'(8 * $urandom_range(0, 79)),
						12'(8 * $urandom_range(0, 59)));
				else
					place_cursor($urandom, $urandom);
			end else if (pick < 93) begin
				load_row($urandom, $urandom, $urandom);
			end else begin
				send(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
			end
		end

		// Let the last draw finish, then give the verdict.
		drain();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
design/tcg_pkg.sv
design/tcg_ram.sv
design/tcg_cursor.sv
design/tcg_glyph_ser.sv
design/text_console_glyph_renderer.sv
verif/text_console_glyph_renderer_checker.sv
verif/text_console_glyph_renderer_tb.sv
